// ----- sv/cia_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_pkg
// Opcodes, status codes, pipeline payload types and helpers for the
// checked integer ALU.
// ----------------------------------------------------------------------------
package cia_pkg;

  localparam logic [4:0] OP_ADD        = 5'd0;
  localparam logic [4:0] OP_ADD_OVF    = 5'd1;
  localparam logic [4:0] OP_ADD_OVF_UN = 5'd2;
  localparam logic [4:0] OP_SUB        = 5'd3;
  localparam logic [4:0] OP_SUB_OVF    = 5'd4;
  localparam logic [4:0] OP_SUB_OVF_UN = 5'd5;
  localparam logic [4:0] OP_MUL        = 5'd6;
  localparam logic [4:0] OP_MUL_OVF    = 5'd7;
  localparam logic [4:0] OP_MUL_OVF_UN = 5'd8;
  localparam logic [4:0] OP_DIV        = 5'd9;
  localparam logic [4:0] OP_DIV_UN     = 5'd10;
  localparam logic [4:0] OP_REM        = 5'd11;
  localparam logic [4:0] OP_REM_UN     = 5'd12;
  localparam logic [4:0] OP_NEG        = 5'd13;
  localparam logic [4:0] OP_AND        = 5'd14;
  localparam logic [4:0] OP_OR         = 5'd15;
  localparam logic [4:0] OP_XOR        = 5'd16;
  localparam logic [4:0] OP_NOT        = 5'd17;
  localparam logic [4:0] OP_SHL        = 5'd18;
  localparam logic [4:0] OP_SHR        = 5'd19;
  localparam logic [4:0] OP_SHR_UN     = 5'd20;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_OVF    = 2'd1;
  localparam logic [1:0] ST_DIV0   = 2'd2;
  localparam logic [1:0] ST_MINDIV = 2'd3;

  localparam logic [5:0] CNT_MASK_32 = 6'h1F;
  localparam logic [5:0] CNT_MASK_64 = 6'h3F;
  localparam logic [63:0] MASK_32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] SIGN_32 = 64'h0000_0000_8000_0000;
  localparam logic [63:0] SIGN_64 = 64'h8000_0000_0000_0000;

  localparam int DIV_STEPS = 64;

  // fields common to every stage after decode
  typedef struct packed {
    logic [4:0]  op;
    logic        wide;
    logic [63:0] res;
    logic [1:0]  st;
    logic        qneg;
    logic        rneg;
  } side_t;

  // decoded item entering the multiplier
  typedef struct packed {
    side_t       side;
    logic [63:0] dx;
    logic [63:0] dy;
    logic [63:0] mx;
    logic [63:0] my;
    logic        mneg;
  } dec_t;

  // divider payload
  typedef struct packed {
    side_t       side;
    logic [63:0] dx;
    logic [63:0] dy;
  } div_in_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] quo;
  } div_acc_t;

  function automatic logic [63:0] mag64(input logic [63:0] x);
    return x[63] ? (64'd0 - x) : x;
  endfunction

  // one restoring step: shift in the next dividend bit, subtract if it fits
  function automatic div_acc_t div_step(input div_acc_t acc, input logic [63:0] y);
    logic [64:0] t;
    logic [64:0] d;
    div_acc_t    n;
    t = {acc.rem, acc.quo[63]};
    d = t - {1'b0, y};
    n.rem = d[64] ? t[63:0] : d[63:0];
    n.quo = {acc.quo[62:0], ~d[64]};
    return n;
  endfunction

endpackage
`default_nettype wire

// ----- sv/cia_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_decode
// Masks operands to width, computes the add, sub, neg, logic and shift
// results and their status, and prepares multiplier and divider operands.
// ----------------------------------------------------------------------------
module cia_decode (
  input  wire logic [4:0]  opcode,
  input  wire logic        wide,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output cia_pkg::dec_t    dec
);

  logic [63:0] mask;
  logic [63:0] sbit;
  logic [63:0] a;
  logic [63:0] b;
  logic [63:0] sa;
  logic [63:0] sb;
  logic [5:0]  cnt;
  logic [63:0] sum;
  logic [63:0] dif;
  logic        sgn_op;

  always_comb begin
    mask = wide ? '1 : cia_pkg::MASK_32;
    sbit = wide ? cia_pkg::SIGN_64 : cia_pkg::SIGN_32;
    a = operand_a & mask;
    b = operand_b & mask;
    sa = wide ? a : {{32{a[31]}}, a[31:0]};
    sb = wide ? b : {{32{b[31]}}, b[31:0]};
    cnt = b[5:0] & (wide ? cia_pkg::CNT_MASK_64 : cia_pkg::CNT_MASK_32);
    sum = (a + b) & mask;
    dif = (a - b) & mask;
    sgn_op = (opcode == cia_pkg::OP_DIV) || (opcode == cia_pkg::OP_REM);

    dec = '0;
    dec.side.op = opcode;
    dec.side.wide = wide;
    dec.side.st = cia_pkg::ST_OK;

    case (opcode)
      cia_pkg::OP_ADD: dec.side.res = sum;
      cia_pkg::OP_ADD_OVF: begin
        dec.side.res = sum;
        if (((a ^ sum) & (b ^ sum) & sbit) != '0) dec.side.st = cia_pkg::ST_OVF;
      end
      cia_pkg::OP_ADD_OVF_UN: begin
        dec.side.res = sum;
        if (sum < a) dec.side.st = cia_pkg::ST_OVF;
      end
      cia_pkg::OP_SUB: dec.side.res = dif;
      cia_pkg::OP_SUB_OVF: begin
        dec.side.res = dif;
        if (((a ^ b) & (a ^ dif) & sbit) != '0) dec.side.st = cia_pkg::ST_OVF;
      end
      cia_pkg::OP_SUB_OVF_UN: begin
        dec.side.res = dif;
        if (b > a) dec.side.st = cia_pkg::ST_OVF;
      end
      cia_pkg::OP_DIV, cia_pkg::OP_REM, cia_pkg::OP_DIV_UN, cia_pkg::OP_REM_UN: begin
        if (b == '0) dec.side.st = cia_pkg::ST_DIV0;
        else if (sgn_op && b == mask && a == sbit) dec.side.st = cia_pkg::ST_MINDIV;
      end
      cia_pkg::OP_NEG: dec.side.res = 64'd0 - a;
      cia_pkg::OP_AND: dec.side.res = a & b;
      cia_pkg::OP_OR:  dec.side.res = a | b;
      cia_pkg::OP_XOR: dec.side.res = a ^ b;
      cia_pkg::OP_NOT: dec.side.res = ~a;
      cia_pkg::OP_SHL: dec.side.res = a << cnt;
      cia_pkg::OP_SHR: dec.side.res = $unsigned($signed(sa) >>> cnt);
      cia_pkg::OP_SHR_UN: dec.side.res = a >> cnt;
      default: dec.side.res = '0;
    endcase

    // divider works on magnitudes for the signed forms
    if (sgn_op) begin
      dec.dx = cia_pkg::mag64(sa);
      dec.dy = cia_pkg::mag64(sb);
      dec.side.qneg = sa[63] ^ sb[63];
      dec.side.rneg = sa[63];
    end else begin
      dec.dx = a;
      dec.dy = b;
    end

    if (opcode == cia_pkg::OP_MUL_OVF) begin
      dec.mx = cia_pkg::mag64(sa);
      dec.my = cia_pkg::mag64(sb);
      dec.mneg = sa[63] ^ sb[63];
    end else begin
      dec.mx = a;
      dec.my = b;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cia_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_mul
// Three-stage 64x64 multiplier: 32x32 partial products, 128-bit sum,
// overflow check and sign fix-up for the mul ops.
// ----------------------------------------------------------------------------
module cia_mul (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  cia_pkg::dec_t      in_dec,
  output logic               out_vld,
  output cia_pkg::div_in_t   out_item
);

  logic [2:0]           vld;
  cia_pkg::dec_t        d1;
  cia_pkg::dec_t        d2;
  logic [63:0]          pp_ll;
  logic [63:0]          pp_lh;
  logic [63:0]          pp_hl;
  logic [63:0]          pp_hh;
  logic [127:0]         prod;
  cia_pkg::div_in_t     fin_next;
  logic [63:0]          hi;
  logic [63:0]          lo;
  logic [63:0]          mask;
  logic [63:0]          limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1 <= in_dec;
      pp_ll <= in_dec.mx[31:0] * in_dec.my[31:0];
      pp_lh <= in_dec.mx[31:0] * in_dec.my[63:32];
      pp_hl <= in_dec.mx[63:32] * in_dec.my[31:0];
      pp_hh <= in_dec.mx[63:32] * in_dec.my[63:32];
      d2 <= d1;
      prod <= {pp_hh, pp_ll} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0};
      out_item <= fin_next;
    end
  end

  always_comb begin
    hi = prod[127:64];
    lo = prod[63:0];
    mask = d2.side.wide ? '1 : cia_pkg::MASK_32;
    limit = (d2.side.wide ? cia_pkg::SIGN_64 : cia_pkg::SIGN_32) - {63'd0, ~d2.mneg};
    fin_next.side = d2.side;
    fin_next.dx = d2.dx;
    fin_next.dy = d2.dy;
    case (d2.side.op)
      cia_pkg::OP_MUL: fin_next.side.res = lo;
      cia_pkg::OP_MUL_OVF: begin
        if (hi != '0 || lo > limit) begin
          fin_next.side.st = cia_pkg::ST_OVF;
          fin_next.side.res = '0;
        end else begin
          fin_next.side.res = d2.mneg ? (64'd0 - lo) : lo;
        end
      end
      cia_pkg::OP_MUL_OVF_UN: begin
        if (hi != '0 || (lo & ~mask) != '0) begin
          fin_next.side.st = cia_pkg::ST_OVF;
          fin_next.side.res = '0;
        end else begin
          fin_next.side.res = lo;
        end
      end
      default: fin_next.side.res = d2.side.res;
    endcase
  end

  assign out_vld = vld[2];

endmodule
`default_nettype wire

// ----- sv/cia_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_div
// Pipelined restoring divider, one quotient bit per stage, carrying the
// rest of the item alongside.
// ----------------------------------------------------------------------------
module cia_div (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          in_vld,
  input  cia_pkg::div_in_t   in_item,
  output logic               out_vld,
  output cia_pkg::side_t     out_side,
  output logic [63:0]        out_quo,
  output logic [63:0]        out_rem
);

  localparam int N = cia_pkg::DIV_STEPS;

  logic [N-1:0]       vld;
  cia_pkg::div_acc_t  acc   [N];
  cia_pkg::div_acc_t  acc_n [N];
  logic [63:0]        dvs   [N];
  cia_pkg::side_t     side  [N];

  always_comb begin
    acc_n[0] = cia_pkg::div_step({64'd0, in_item.dx}, in_item.dy);
    for (int k = 1; k < N; k++) begin
      acc_n[k] = cia_pkg::div_step(acc[k-1], dvs[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[N-2:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc[0] <= acc_n[0];
      dvs[0] <= in_item.dy;
      side[0] <= in_item.side;
      for (int k = 1; k < N; k++) begin
        acc[k] <= acc_n[k];
        dvs[k] <= dvs[k-1];
        side[k] <= side[k-1];
      end
    end
  end

  assign out_vld  = vld[N-1];
  assign out_side = side[N-1];
  assign out_quo  = acc[N-1].quo;
  assign out_rem  = acc[N-1].rem;

endmodule
`default_nettype wire

// ----- sv/checked_integer_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// checked_integer_alu
// Integer ALU for 32/64-bit add, sub, mul, div, rem, logic and shift ops
// with overflow, divide-by-zero and MIN/-1 status.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries opcode, wide, operand_a and
//   operand_b. Output channel out_valid/out_ready carries result_value and
//   status, one result per input, in order.
//   From input transfer to out_valid an item passes one decode stage,
//   three multiplier stages, 64 divider stages (one quotient bit each) and
//   the output register. Every op takes the same path, so order is kept.
//   One item per cycle unless stalled; the 64-stage divider sets the latency.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_ready drops in the same cycle; nothing is lost or repeated.
//   Synchronous reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module checked_integer_alu (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [4:0]  opcode,
  input  wire logic        wide,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      result_value,
  output logic [1:0]       status
);

  logic              en;
  cia_pkg::dec_t     dec_c;
  cia_pkg::dec_t     dec;
  logic              dec_vld;
  logic              mul_vld;
  cia_pkg::div_in_t  mul_item;
  logic              div_vld;
  cia_pkg::side_t    div_side;
  logic [63:0]       div_quo;
  logic [63:0]       div_rem;
  logic [63:0]       res_next;
  logic [63:0]       mask;

  // advance everything unless a result is waiting
  assign en = ~out_valid | out_ready;
  assign in_ready = en;

  cia_decode u_decode (
    .opcode    (opcode),
    .wide      (wide),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .dec       (dec_c)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_vld <= 1'b0;
    end else if (en) begin
      dec_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dec <= dec_c;
    end
  end

  cia_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (dec_vld),
    .in_dec   (dec),
    .out_vld  (mul_vld),
    .out_item (mul_item)
  );

  cia_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_vld   (mul_vld),
    .in_item  (mul_item),
    .out_vld  (div_vld),
    .out_side (div_side),
    .out_quo  (div_quo),
    .out_rem  (div_rem)
  );

  always_comb begin
    mask = div_side.wide ? '1 : cia_pkg::MASK_32;
    case (div_side.op)
      cia_pkg::OP_DIV, cia_pkg::OP_DIV_UN:
        res_next = div_side.qneg ? (64'd0 - div_quo) : div_quo;
      cia_pkg::OP_REM, cia_pkg::OP_REM_UN:
        res_next = div_side.rneg ? (64'd0 - div_rem) : div_rem;
      default: res_next = div_side.res;
    endcase
    if (div_side.st != cia_pkg::ST_OK) res_next = '0;
    res_next = res_next & mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result_value <= res_next;
      status <= div_side.st;
    end
  end

endmodule
`default_nettype wire

// ----- sv/cia_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cia_checker
// Port-level checks for the checked integer ALU.
// ----------------------------------------------------------------------------
module cia_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] result_value,
  input wire logic [1:0]  status
);

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("output transfer changed while stalled");

  // failed ops give a zero value
  a_zero_on_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cia_pkg::ST_OK |-> result_value == '0)
    else $error("nonzero value with error status");

  // input side stalls exactly when a result is held
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the output stall");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind checked_integer_alu cia_checker u_cia_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_value (result_value),
  .status       (status)
);
`default_nettype wire

// ----- dv/tb_checked_integer_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_checked_integer_alu
// Self-checking bench for the checked integer ALU: directed corner cases,
// then random instructions in bursts, with a stalling receiver. Results are
// predicted per instruction and compared in order, field by field.
// ----------------------------------------------------------------------------
module tb_checked_integer_alu;

  typedef struct {
    logic [63:0] value;
    logic [1:0]  st;
  } alu_result_t;

  class alu_scoreboard;
    alu_result_t pending[$];
    int          errors;

    // predict one instruction
    function alu_result_t compute(logic [4:0] op, logic w, logic [63:0] ain,
                                  logic [63:0] bin);
      logic [63:0]  mask, sbit, a, b, sa, sb, r, q, rm;
      logic [127:0] prod;
      logic [5:0]   cnt;
      logic [1:0]   st;
      logic         ng;
      alu_result_t  res;
      mask = w ? '1 : cia_pkg::MASK_32;
      sbit = w ? cia_pkg::SIGN_64 : cia_pkg::SIGN_32;
      a = ain & mask;
      b = bin & mask;
      sa = w ? a : {{32{a[31]}}, a[31:0]};
      sb = w ? b : {{32{b[31]}}, b[31:0]};
      cnt = b[5:0] & (w ? cia_pkg::CNT_MASK_64 : cia_pkg::CNT_MASK_32);
      r = '0;
      st = cia_pkg::ST_OK;
      case (op)
        cia_pkg::OP_ADD: r = a + b;
        cia_pkg::OP_ADD_OVF: begin
          r = (a + b) & mask;
          if (((a ^ r) & (b ^ r) & sbit) != 0) st = cia_pkg::ST_OVF;
        end
        cia_pkg::OP_ADD_OVF_UN: begin
          r = (a + b) & mask;
          if (r < a) st = cia_pkg::ST_OVF;
        end
        cia_pkg::OP_SUB: r = a - b;
        cia_pkg::OP_SUB_OVF: begin
          r = (a - b) & mask;
          if (((a ^ b) & (a ^ r) & sbit) != 0) st = cia_pkg::ST_OVF;
        end
        cia_pkg::OP_SUB_OVF_UN: begin
          r = a - b;
          if (b > a) st = cia_pkg::ST_OVF;
        end
        cia_pkg::OP_MUL: r = a * b;
        cia_pkg::OP_MUL_OVF: begin
          ng = sa[63] ^ sb[63];
          prod = {64'd0, cia_pkg::mag64(sa)} * {64'd0, cia_pkg::mag64(sb)};
          if (prod[127:64] != 0 ||
              prod[63:0] > (ng ? cia_pkg::SIGN_64 : cia_pkg::SIGN_64 - 1) ||
              (!w && prod[63:0] > (ng ? 64'h8000_0000 : 64'h7FFF_FFFF)))
            st = cia_pkg::ST_OVF;
          else
            r = ng ? 64'd0 - prod[63:0] : prod[63:0];
        end
        cia_pkg::OP_MUL_OVF_UN: begin
          prod = {64'd0, a} * {64'd0, b};
          if (prod[127:64] != 0 || (prod[63:0] & ~mask) != 0) st = cia_pkg::ST_OVF;
          else r = prod[63:0];
        end
        cia_pkg::OP_DIV, cia_pkg::OP_REM: begin
          if (b == 0) st = cia_pkg::ST_DIV0;
          else if (b == mask && a == sbit) st = cia_pkg::ST_MINDIV;
          else begin
            q = cia_pkg::mag64(sa) / cia_pkg::mag64(sb);
            rm = cia_pkg::mag64(sa) % cia_pkg::mag64(sb);
            if (sa[63] ^ sb[63]) q = 64'd0 - q;
            if (sa[63]) rm = 64'd0 - rm;
            r = (op == cia_pkg::OP_DIV) ? q : rm;
          end
        end
        cia_pkg::OP_DIV_UN, cia_pkg::OP_REM_UN: begin
          if (b == 0) st = cia_pkg::ST_DIV0;
          else r = (op == cia_pkg::OP_DIV_UN) ? a / b : a % b;
        end
        cia_pkg::OP_NEG: r = 64'd0 - a;
        cia_pkg::OP_AND: r = a & b;
        cia_pkg::OP_OR: r = a | b;
        cia_pkg::OP_XOR: r = a ^ b;
        cia_pkg::OP_NOT: r = ~a;
        cia_pkg::OP_SHL: r = a << cnt;
        cia_pkg::OP_SHR: r = $signed(sa) >>> cnt;
        cia_pkg::OP_SHR_UN: r = a >> cnt;
        default: r = '0;
      endcase
      if (st != cia_pkg::ST_OK) r = '0;
      res.value = r & mask;
      res.st = st;
      return res;
    endfunction

    function void note_instruction(logic [4:0] op, logic w, logic [63:0] a,
                                   logic [63:0] b);
      pending.push_back(compute(op, w, a, b));
    endfunction

    function void check_result(logic [63:0] value, logic [1:0] st);
      alu_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $time, value, st);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (value !== exp_r.value) begin
        $display("%0t: result_value expected %h actual %h", $time, exp_r.value, value);
        errors++;
      end
      if (st !== exp_r.st) begin
        $display("%0t: status expected %0d actual %0d", $time, exp_r.st, st);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [4:0]  opcode;
  logic        wide;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] result_value;
  logic [1:0]  status;
  logic        stim_done;

  alu_scoreboard sb = new();

  checked_integer_alu DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode), .wide(wide), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_ready(out_ready),
    .result_value(result_value), .status(status)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // record both channels at the edge
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.note_instruction(opcode, wide, operand_a, operand_b);
    if (!rst && out_valid && out_ready) sb.check_result(result_value, status);
  end

  // receiver stall pattern: runs of ready and runs of stall
  initial begin
    int run;
    out_ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      run = $urandom_range(1, 20);
      out_ready <= ($urandom_range(0, 3) != 0);
      repeat (run) @(posedge clk);
    end
  end

  function automatic logic [63:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return cia_pkg::SIGN_64;
      3: return cia_pkg::SIGN_32;
      4: return 64'h7FFF_FFFF_FFFF_FFFF;
      5: return {$urandom(), 32'h7FFF_FFFF};
      6: return 64'($urandom_range(0, 70));
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  // hold one transfer until accepted
  task automatic send_instruction(logic [4:0] op, logic w, logic [63:0] a,
                                  logic [63:0] b);
    in_valid  <= 1'b1;
    opcode    <= op;
    wide      <= w;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  initial begin
    int burst;
    int sent;
    in_valid  = 1'b0;
    opcode    = '0;
    wide      = 1'b0;
    operand_a = '0;
    operand_b = '0;
    stim_done = 1'b0;
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed corners: divide by zero, MIN by minus one, overflow edges, shifts, unused opcodes
    send_instruction(cia_pkg::OP_DIV, 1'b1, cia_pkg::SIGN_64, '1);
    send_instruction(cia_pkg::OP_REM, 1'b0, {32'hDEAD_BEEF, cia_pkg::SIGN_32[31:0]},
                     {32'h1, 32'hFFFF_FFFF});
    send_instruction(cia_pkg::OP_DIV_UN, 1'b1, 64'd5, '0);
    send_instruction(cia_pkg::OP_REM, 1'b0, 64'd7, 64'hFFFF_FFFF_0000_0000);
    send_instruction(cia_pkg::OP_DIV, 1'b0, 64'hFFFF_FFF9, 64'd2);
    send_instruction(cia_pkg::OP_REM, 1'b1, 64'hFFFF_FFFF_FFFF_FFF9, 64'd2);
    send_instruction(cia_pkg::OP_ADD_OVF, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1);
    send_instruction(cia_pkg::OP_ADD_OVF_UN, 1'b0, 64'hFFFF_FFFF, 64'd1);
    send_instruction(cia_pkg::OP_SUB_OVF, 1'b1, cia_pkg::SIGN_64, 64'd1);
    send_instruction(cia_pkg::OP_SUB_OVF_UN, 1'b0, 64'd0, 64'd1);
    send_instruction(cia_pkg::OP_MUL_OVF, 1'b1, cia_pkg::SIGN_64, 64'd1);
    send_instruction(cia_pkg::OP_MUL_OVF, 1'b1, 64'h4000_0000_0000_0000, 64'd2);
    send_instruction(cia_pkg::OP_MUL_OVF, 1'b0, 64'hFFFF_8000, 64'h0001_0000);
    send_instruction(cia_pkg::OP_MUL_OVF_UN, 1'b1, 64'h1_0000_0000, 64'h1_0000_0000);
    send_instruction(cia_pkg::OP_MUL_OVF_UN, 1'b0, 64'h1_0000, 64'h1_0000);
    send_instruction(cia_pkg::OP_NEG, 1'b1, cia_pkg::SIGN_64, '0);
    send_instruction(cia_pkg::OP_NOT, 1'b0, '0, '1);
    send_instruction(cia_pkg::OP_SHL, 1'b0, '1, 64'd33);
    send_instruction(cia_pkg::OP_SHR, 1'b1, cia_pkg::SIGN_64, 64'd127);
    send_instruction(cia_pkg::OP_SHR, 1'b0, cia_pkg::SIGN_32, 64'd31);
    send_instruction(cia_pkg::OP_SHR_UN, 1'b1, '1, 64'd63);
    send_instruction(5'd21, 1'b1, '1, '1);
    send_instruction(5'd31, 1'b0, '1, '1);

    sent = 0;
    while (sent < 500) begin
      burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 12);
      repeat (burst) begin
        send_instruction(($urandom_range(0, 15) == 0) ? 5'($urandom_range(21, 31))
                                                      : 5'($urandom_range(0, 20)),
                         1'($urandom()), pick_operand(), pick_operand());
        sent++;
      end
      idle_gap($urandom_range(0, 6));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    @(posedge stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
